FILE: src/assert_macros.svh
// Assertion shorthands for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/stok_pkg.sv
`timescale 1ns / 1ps

package stok_pkg;

   localparam int OFFSET_WIDTH_DEF = 24;
   localparam int LINE_WIDTH_DEF   = 16;
   localparam int COLUMN_WIDTH_DEF = 16;

   typedef enum logic [2:0] {
      MODE_IDLE   = 3'd0,
      MODE_IDENT  = 3'd1,
      MODE_NUMBER = 3'd2,
      MODE_STRING = 3'd3,
      MODE_ESCAPE = 3'd4,
      MODE_OPER   = 3'd5
   } scan_mode_type;

   localparam logic [4:0] KIND_EOF     = 5'd0;
   localparam logic [4:0] KIND_INT     = 5'd1;
   localparam logic [4:0] KIND_IDENT   = 5'd4;
   localparam logic [4:0] KIND_NUMBER  = 5'd5;
   localparam logic [4:0] KIND_STRING  = 5'd6;
   localparam logic [4:0] KIND_LPAREN  = 5'd7;
   localparam logic [4:0] KIND_RPAREN  = 5'd8;
   localparam logic [4:0] KIND_LBRACE  = 5'd9;
   localparam logic [4:0] KIND_RBRACE  = 5'd10;
   localparam logic [4:0] KIND_SEMI    = 5'd11;
   localparam logic [4:0] KIND_COLON   = 5'd12;
   localparam logic [4:0] KIND_COMMA   = 5'd13;
   localparam logic [4:0] KIND_PLUS    = 5'd14;
   localparam logic [4:0] KIND_MINUS   = 5'd15;
   localparam logic [4:0] KIND_STAR    = 5'd16;
   localparam logic [4:0] KIND_SLASH   = 5'd17;
   localparam logic [4:0] KIND_PERCENT = 5'd18;
   localparam logic [4:0] KIND_EQ_EQ   = 5'd19;
   localparam logic [4:0] KIND_ASSIGN  = 5'd20;
   localparam logic [4:0] KIND_NOT_EQ  = 5'd21;
   localparam logic [4:0] KIND_LT_EQ   = 5'd23;
   localparam logic [4:0] KIND_GT      = 5'd26;
   localparam logic [4:0] KIND_UNKNOWN = 5'd27;

   localparam logic [7:0] CH_NEWLINE    = 8'h0A;
   localparam logic [7:0] CH_TAB        = 8'h09;
   localparam logic [7:0] CH_CR         = 8'h0D;
   localparam logic [7:0] CH_SPACE      = 8'h20;
   localparam logic [7:0] CH_QUOTE      = 8'h22;
   localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CH_EQUAL      = 8'h3D;
   localparam logic [7:0] CH_BANG       = 8'h21;
   localparam logic [7:0] CH_LESS       = 8'h3C;
   localparam logic [7:0] CH_GREATER    = 8'h3E;

   localparam logic [1:0] OP_EQUAL   = 2'd0;
   localparam logic [1:0] OP_BANG    = 2'd1;
   localparam logic [1:0] OP_LESS    = 2'd2;
   localparam logic [1:0] OP_GREATER = 2'd3;

   function automatic logic is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_space(logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic logic is_ident_char(logic [7:0] c);
      return is_alpha(c) || is_digit(c) || c == CH_UNDERSCORE;
   endfunction

   function automatic logic is_op_lead(logic [7:0] c);
      return c == CH_EQUAL || c == CH_BANG || c == CH_LESS || c == CH_GREATER;
   endfunction

   function automatic logic [1:0] op_code(logic [7:0] c);
      logic [1:0] r;
      priority if (c == CH_EQUAL) r = OP_EQUAL;
      else if (c == CH_BANG) r = OP_BANG;
      else if (c == CH_LESS) r = OP_LESS;
      else r = OP_GREATER;
      return r;
   endfunction

   function automatic logic [4:0] symbol_kind(logic [7:0] c);
      logic [4:0] k;
      case (c)
         "(":     k = KIND_LPAREN;
         ")":     k = KIND_RPAREN;
         "{":     k = KIND_LBRACE;
         "}":     k = KIND_RBRACE;
         ";":     k = KIND_SEMI;
         ":":     k = KIND_COLON;
         ",":     k = KIND_COMMA;
         "+":     k = KIND_PLUS;
         "-":     k = KIND_MINUS;
         "*":     k = KIND_STAR;
         "/":     k = KIND_SLASH;
         "%":     k = KIND_PERCENT;
         default: k = KIND_UNKNOWN;
      endcase
      return k;
   endfunction

   function automatic logic [2:0] precedence_of(logic [4:0] k);
      logic [2:0] p;
      priority if (k >= KIND_STAR && k <= KIND_PERCENT) p = 3'd5;
      else if (k == KIND_PLUS || k == KIND_MINUS) p = 3'd4;
      else if (k >= KIND_LT_EQ && k <= KIND_GT) p = 3'd3;
      else if (k == KIND_EQ_EQ || k == KIND_NOT_EQ) p = 3'd2;
      else if (k == KIND_ASSIGN) p = 3'd1;
      else p = 3'd0;
      return p;
   endfunction

   // keyword spellings, left aligned and zero padded to eight bytes
   function automatic logic [63:0] kw_text(logic [1:0] k);
      logic [63:0] t;
      unique case (k)
         2'd0:    t = {"int", 40'h0};
         2'd1:    t = {"return", 16'h0};
         default: t = {"var", 40'h0};
      endcase
      return t;
   endfunction

   function automatic logic [2:0] kw_len(logic [1:0] k);
      return (k == 2'd1) ? 3'd6 : 3'd3;
   endfunction

   // drop keyword candidates that byte c at position pos rules out;
   // fits is low once the identifier is eight bytes or longer
   function automatic logic [2:0] kw_filter(logic [2:0] cand, logic fits, logic [2:0] pos,
                                            logic [7:0] c);
      logic [2:0]  r;
      logic [63:0] t;
      r = cand;
      for (int k = 0; k < 3; k++) begin
         t = kw_text(2'(k));
         if (!fits || pos >= kw_len(2'(k)) || t[63 - 8 * pos -: 8] != c) r[k] = 1'b0;
      end
      return r;
   endfunction

   function automatic logic [4:0] kw_kind(logic [2:0] cand, logic fits, logic [2:0] len);
      logic [4:0] kind;
      kind = KIND_IDENT;
      for (int k = 0; k < 3; k++) begin
         if (cand[k] && fits && len == kw_len(2'(k))) kind = KIND_INT + 5'(k);
      end
      return kind;
   endfunction

endpackage

FILE: src/stok_if.sv
`timescale 1ns / 1ps

interface stok_char_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       char_valid;
   logic       end_of_source;

   modport source(output valid, char_byte, char_valid, end_of_source, input ready);
   modport sink(input valid, char_byte, char_valid, end_of_source, output ready);
endinterface

interface stok_token_if #(
   parameter int OFFSET_WIDTH = stok_pkg::OFFSET_WIDTH_DEF,
   parameter int LINE_WIDTH   = stok_pkg::LINE_WIDTH_DEF,
   parameter int COLUMN_WIDTH = stok_pkg::COLUMN_WIDTH_DEF
);
   logic                    valid;
   logic                    ready;
   logic [4:0]              token_kind;
   logic [OFFSET_WIDTH-1:0] start_offset;
   logic [OFFSET_WIDTH-1:0] text_length;
   logic [LINE_WIDTH-1:0]   token_line;
   logic [COLUMN_WIDTH-1:0] start_column;
   logic [7:0]              unknown_byte;
   logic [2:0]              precedence;
   logic                    last_of_run;

   modport source(output valid, token_kind, start_offset, text_length, token_line,
                  start_column, unknown_byte, precedence, last_of_run, input ready);
   modport sink(input valid, token_kind, start_offset, text_length, token_line,
                start_column, unknown_byte, precedence, last_of_run, output ready);
endinterface

FILE: src/source_tokenizer.sv
`timescale 1ns / 1ps
// Latency: tokens caused by a byte are offered from the cycle after that byte's beat.
// Throughput: one byte per cycle while each byte yields at most one token and the
//   token side does not hold it back; a byte that yields k tokens (k up to 3) holds
//   off the next byte until the result register has drained them, one per output beat.
// Reset (synchronous, active high): scanner idle, offset 0, line and column 1,
//   end-of-source flag cleared, undelivered tokens dropped.
module source_tokenizer #(
   parameter int OFFSET_WIDTH = stok_pkg::OFFSET_WIDTH_DEF,
   parameter int LINE_WIDTH   = stok_pkg::LINE_WIDTH_DEF,
   parameter int COLUMN_WIDTH = stok_pkg::COLUMN_WIDTH_DEF
) (
   input logic          clock,
   input logic          reset,
   stok_char_if.sink    req_chan,
   stok_token_if.source rsp_chan
);
   import stok_pkg::*;

   typedef struct packed {
      logic [4:0]              kind;
      logic [OFFSET_WIDTH-1:0] off;
      logic [OFFSET_WIDTH-1:0] len;
      logic [LINE_WIDTH-1:0]   line;
      logic [COLUMN_WIDTH-1:0] col;
      logic [7:0]              ub;
   } tok_type;

   function automatic logic mode_open(scan_mode_type m);
      return m == MODE_IDENT || m == MODE_NUMBER || m == MODE_STRING ||
             m == MODE_ESCAPE || m == MODE_OPER;
   endfunction

   function automatic tok_type close_tok(scan_mode_type m, logic [1:0] p, logic [2:0] kw,
                                         logic [OFFSET_WIDTH-1:0] so,
                                         logic [OFFSET_WIDTH-1:0] ln,
                                         logic [LINE_WIDTH-1:0] sl,
                                         logic [COLUMN_WIDTH-1:0] sc);
      tok_type t;
      logic    fits;
      fits   = (ln >> 3) == '0;
      t.off  = so;
      t.len  = ln;
      t.line = sl;
      t.col  = sc;
      t.ub   = 8'h00;
      unique case (m)
         MODE_IDENT:               t.kind = kw_kind(kw, fits, ln[2:0]);
         MODE_NUMBER:              t.kind = KIND_NUMBER;
         MODE_STRING, MODE_ESCAPE: t.kind = KIND_STRING;
         MODE_OPER: begin
            t.kind = KIND_ASSIGN + {2'b00, p, 1'b0};
            t.len  = OFFSET_WIDTH'(1);
         end
         default:                  t.kind = KIND_EOF;
      endcase
      return t;
   endfunction

   scan_mode_type           mode_ff, mode_byte, mode_in;
   logic [1:0]              pend_ff, pend_in;
   logic [2:0]              kwc_ff, kwc_in;
   logic [OFFSET_WIDTH-1:0] tso_ff, tso_in, tlen_ff, tlen_in, co_ff, co_in;
   logic [LINE_WIDTH-1:0]   tsl_ff, tsl_in, cl_ff, cl_in;
   logic [COLUMN_WIDTH-1:0] tsc_ff, tsc_in, cc_ff, cc_in;
   logic                    ended_ff, ended_in;
   tok_type                 slot_ff [3];
   tok_type                 slot_in [3];
   logic [1:0]              count_ff, count_in, idx_ff;

   logic [7:0]              c;
   logic                    byte_ok, eos;
   logic [OFFSET_WIDTH-1:0] co_sat, tlen_sat;
   logic [LINE_WIDTH-1:0]   cl_sat;
   logic [COLUMN_WIDTH-1:0] cc_sat;
   logic                    r1_en, r2_en, r3_en, start;
   tok_type                 r1, r2, r3, mid, eof_tok;
   logic                    mid_en;
   logic                    req_fire, rsp_fire, take, last_pos, drain_last;
   tok_type                 cur;

   assign c        = req_chan.char_byte;
   assign byte_ok  = req_chan.char_valid;
   assign eos      = req_chan.end_of_source;
   assign co_sat   = (&co_ff) ? co_ff : co_ff + 1'b1;
   assign tlen_sat = (&tlen_ff) ? tlen_ff : tlen_ff + 1'b1;
   assign cl_sat   = (&cl_ff) ? cl_ff : cl_ff + 1'b1;
   assign cc_sat   = (&cc_ff) ? cc_ff : cc_ff + 1'b1;

   // scanner step for one byte; the end-of-source flush is in the block below
   always_comb begin
      mode_byte = mode_ff;
      pend_in   = pend_ff;
      kwc_in    = kwc_ff;
      tso_in    = tso_ff;
      tsl_in    = tsl_ff;
      tsc_in    = tsc_ff;
      tlen_in   = tlen_ff;
      r1_en     = 1'b0;
      r2_en     = 1'b0;
      start     = 1'b0;
      r1        = close_tok(mode_ff, pend_ff, kwc_ff, tso_ff, tlen_ff, tsl_ff, tsc_ff);
      r2        = '{kind: symbol_kind(c), off: co_ff, len: OFFSET_WIDTH'(1), line: cl_ff,
                    col: cc_ff, ub: (symbol_kind(c) == KIND_UNKNOWN) ? c : 8'h00};
      if (byte_ok) begin
         unique case (mode_ff)
            MODE_IDENT: begin
               if (is_ident_char(c)) begin
                  kwc_in  = kw_filter(kwc_ff, (tlen_ff >> 3) == '0, tlen_ff[2:0], c);
                  tlen_in = tlen_sat;
               end else begin
                  r1_en = 1'b1;
                  start = 1'b1;
               end
            end
            MODE_NUMBER: begin
               if (is_digit(c)) begin
                  tlen_in = tlen_sat;
               end else begin
                  r1_en = 1'b1;
                  start = 1'b1;
               end
            end
            MODE_STRING: begin
               if (c == CH_QUOTE) begin
                  r1_en     = 1'b1;
                  mode_byte = MODE_IDLE;
               end else begin
                  tlen_in = tlen_sat;
                  if (c == CH_BACKSLASH) mode_byte = MODE_ESCAPE;
               end
            end
            MODE_ESCAPE: begin
               tlen_in   = tlen_sat;
               mode_byte = MODE_STRING;
            end
            MODE_OPER: begin
               if (c == CH_EQUAL) begin
                  r1_en     = 1'b1;
                  r1.kind   = KIND_EQ_EQ + {2'b00, pend_ff, 1'b0};
                  r1.len    = OFFSET_WIDTH'(2);
                  mode_byte = MODE_IDLE;
               end else begin
                  r1_en = 1'b1;
                  start = 1'b1;
               end
            end
            default: start = 1'b1;
         endcase

         if (start) begin
            mode_byte = MODE_IDLE;
            priority if (is_alpha(c) || c == CH_UNDERSCORE) begin
               tso_in    = co_ff;
               tsl_in    = cl_ff;
               tsc_in    = cc_ff;
               kwc_in    = kw_filter(3'b111, 1'b1, 3'd0, c);
               tlen_in   = OFFSET_WIDTH'(1);
               mode_byte = MODE_IDENT;
            end else if (is_digit(c)) begin
               tso_in    = co_ff;
               tsl_in    = cl_ff;
               tsc_in    = cc_ff;
               tlen_in   = OFFSET_WIDTH'(1);
               mode_byte = MODE_NUMBER;
            end else if (c == CH_QUOTE) begin
               // text starts after the quote, position is the quote's
               tso_in    = co_sat;
               tsl_in    = cl_ff;
               tsc_in    = cc_ff;
               tlen_in   = '0;
               mode_byte = MODE_STRING;
            end else if (is_op_lead(c)) begin
               tso_in    = co_ff;
               tsl_in    = cl_ff;
               tsc_in    = cc_ff;
               tlen_in   = OFFSET_WIDTH'(1);
               pend_in   = op_code(c);
               mode_byte = MODE_OPER;
            end else if (!is_space(c)) begin
               r2_en = 1'b1;
            end
         end
      end
   end

   always_comb begin
      co_in = byte_ok ? co_sat : co_ff;
      cl_in = (byte_ok && c == CH_NEWLINE) ? cl_sat : cl_ff;
      cc_in = byte_ok ? ((c == CH_NEWLINE) ? COLUMN_WIDTH'(1) : cc_sat) : cc_ff;

      r3_en    = eos && mode_open(mode_byte);
      r3       = close_tok(mode_byte, pend_in, kwc_in, tso_in, tlen_in, tsl_in, tsc_in);
      eof_tok  = '{kind: KIND_EOF, off: co_in, len: '0, line: cl_in, col: cc_in, ub: 8'h00};
      mode_in  = eos ? MODE_IDLE : mode_byte;
      ended_in = eos;

      // a symbol token leaves the scanner idle, so r2 and r3 never meet
      mid_en     = r2_en || r3_en;
      mid        = r2_en ? r2 : r3;
      slot_in[0] = r1_en ? r1 : (mid_en ? mid : eof_tok);
      slot_in[1] = (r1_en && mid_en) ? mid : eof_tok;
      slot_in[2] = eof_tok;
      count_in   = ended_ff ? 2'd0 :
                   {1'b0, r1_en} + {1'b0, mid_en} + {1'b0, eos};
   end

   assign req_fire   = req_chan.valid && req_chan.ready;
   assign rsp_fire   = rsp_chan.valid && rsp_chan.ready;
   assign take       = req_fire && !ended_ff;
   assign last_pos   = idx_ff == count_ff - 2'd1;
   assign drain_last = rsp_fire && last_pos;

   assign req_chan.ready = (count_ff == 2'd0) || drain_last;

   assign cur                   = slot_ff[idx_ff];
   assign rsp_chan.valid        = count_ff != 2'd0;
   assign rsp_chan.token_kind   = cur.kind;
   assign rsp_chan.start_offset = cur.off;
   assign rsp_chan.text_length  = cur.len;
   assign rsp_chan.token_line   = cur.line;
   assign rsp_chan.start_column = cur.col;
   assign rsp_chan.unknown_byte = cur.ub;
   assign rsp_chan.precedence   = precedence_of(cur.kind);
   assign rsp_chan.last_of_run  = last_pos;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         pend_ff  <= '0;
         kwc_ff   <= 3'b111;
         tso_ff   <= '0;
         tsl_ff   <= LINE_WIDTH'(1);
         tsc_ff   <= COLUMN_WIDTH'(1);
         tlen_ff  <= '0;
         co_ff    <= '0;
         cl_ff    <= LINE_WIDTH'(1);
         cc_ff    <= COLUMN_WIDTH'(1);
         ended_ff <= 1'b0;
         count_ff <= 2'd0;
         idx_ff   <= 2'd0;
      end else begin
         if (take) begin
            mode_ff  <= mode_in;
            pend_ff  <= pend_in;
            kwc_ff   <= kwc_in;
            tso_ff   <= tso_in;
            tsl_ff   <= tsl_in;
            tsc_ff   <= tsc_in;
            tlen_ff  <= tlen_in;
            co_ff    <= co_in;
            cl_ff    <= cl_in;
            cc_ff    <= cc_in;
            ended_ff <= ended_in;
         end
         if (req_fire) begin
            count_ff <= count_in;
            idx_ff   <= 2'd0;
         end else if (rsp_fire) begin
            if (last_pos) count_ff <= 2'd0;
            else idx_ff <= idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) slot_ff <= slot_in;
   end

endmodule

FILE: src/stok_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stok_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_last,
   input logic [4:0] rsp_kind
);
   import stok_pkg::*;

   `ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_kind) && $stable(rsp_last), "stalled token beat changed")
   `ASSERT_NXT(a_run_continues, clock, reset, rsp_valid && rsp_ready && !rsp_last, rsp_valid, "token run broken before its last beat")
   `ASSERT_IMP(a_run_blocks_req, clock, reset, rsp_valid && !rsp_last, !req_ready, "byte taken while a token run is still open")
   `ASSERT_IMP(a_eof_last, clock, reset, rsp_valid && rsp_kind == KIND_EOF, rsp_last, "end token not last of its run")

endmodule

bind source_tokenizer stok_checker u_stok_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_last  (rsp_chan.last_of_run),
   .rsp_kind  (rsp_chan.token_kind)
);
